// ===== src/cqmva_pkg.sv =====
// Shared types and constants for the complex Q8.8 matrix-vector accumulator.
package cqmva_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam int ROW_COUNT_W = 9;
  localparam int COL_COUNT_W = 13;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd16;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 13'd64;

  typedef struct packed {
    logic signed [15:0] mat_real;
    logic signed [15:0] mat_imag;
    logic signed [15:0] vec_real;
    logic signed [15:0] vec_imag;
  } in_word_t;

  typedef struct packed {
    logic        [7:0]  row_index;
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic               last;
  } out_word_t;

  // Position flags that travel with each word down the pipeline.
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic last_row;
  } item_flags_t;

endpackage

// ===== src/cqmva_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module cqmva_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cqmva_ctrl.sv =====
// Configuration registers and row/column position counters.
module cqmva_ctrl
  import cqmva_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        step,
  output logic [$clog2(MAX_ROWS)-1:0] row,
  output item_flags_t                 flags
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ROWS_W = ROW_W + 1;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int COLS_W = COL_W + 1;

  logic [ROW_COUNT_W-1:0] row_count_r, row_count_nxt;
  logic [COL_COUNT_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0]       row_pos_r, row_pos_nxt;
  logic [COL_W-1:0]       col_pos_r, col_pos_nxt;
  logic [ROWS_W-1:0]      eff_rows;
  logic [COLS_W-1:0]      eff_cols;

  // A zero count behaves as one, and a count beyond the storage is clamped.
  always_comb begin
    if (row_count_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = ROWS_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      eff_cols = COLS_W'(1);
    end else if (32'(col_count_r) > 32'(MAX_COLS)) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = COLS_W'(col_count_r);
    end
  end

  assign row             = row_pos_r;
  assign flags.first_col = (col_pos_r == '0);
  assign flags.last_col  = (({1'b0, col_pos_r} + COLS_W'(1)) == eff_cols);
  assign flags.last_row  = (({1'b0, row_pos_r} + ROWS_W'(1)) == eff_rows);

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    if (cfg_we) begin
      // Any recognized register write restarts the frame.
      case (cfg_index)
        REG_ROW_COUNT: begin
          row_count_nxt = cfg_data[ROW_COUNT_W-1:0];
          row_pos_nxt   = '0;
          col_pos_nxt   = '0;
        end
        REG_COLUMN_COUNT: begin
          col_count_nxt = cfg_data[COL_COUNT_W-1:0];
          row_pos_nxt   = '0;
          col_pos_nxt   = '0;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      if (flags.last_row) begin
        row_pos_nxt = '0;
        col_pos_nxt = flags.last_col ? '0 : col_pos_r + COL_W'(1);
      end else begin
        row_pos_nxt = row_pos_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RESET;
      col_count_r <= COL_COUNT_RESET;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
    end
  end

endmodule

// ===== src/complex_q8_matvec_accumulator_unit.sv =====
// Top level of the complex Q8.8 matrix-vector accumulator.
//
//   Channel | Ports                            | Word
//   --------+----------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data      | matrix element + vector element
//   output  | out_valid, out_stall, out_data   | row result on the last column
//   config  | cfg_we, cfg_index, cfg_data      | row_count, column_count
//
// One input word is taken every cycle unless in_stall is high. A word passes through
// multiply and accumulator read, pair sum, then saturating accumulate, write-back
// and result formatting, and a result is held in the output register for out_data.
// Reset is synchronous on rst_n and clears control state only; the accumulator RAM
// is written by the first column before it is ever read. Input stalls only when a
// result-producing word waits on a stalled output.
module complex_q8_matvec_accumulator_unit
  import cqmva_pkg::*;
#(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = $clog2(MAX_ROWS);

  function automatic logic [15:0] scale_out(input logic [31:0] acc);
    logic [31:0] sh;
    sh = 32'($signed(acc) >>> FRAC_BITS);
    if (sh[31:15] == '0 || sh[31:15] == '1) begin
      scale_out = sh[15:0];
    end else begin
      scale_out = sh[31] ? 16'h8000 : 16'h7FFF;
    end
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [32:0] sum);
    logic [33:0] s;
    s = {{2{acc[31]}}, acc} + {sum[32], sum};
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      sat_add = s[31:0];
    end else begin
      sat_add = s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  endfunction

  logic              adv;
  logic              accept;
  logic [ROW_W-1:0]  cur_row;
  item_flags_t       cur_flags;

  // Stage 1: products and accumulator read
  logic                s1_valid_r;
  logic [ROW_W-1:0]    s1_row_r;
  item_flags_t         s1_flags_r;
  logic signed [31:0]  p_rr_r, p_in_r, p_iv_r, p_ir_r;
  logic signed [15:0]  neg_vi;
  logic                byp_hit_r;
  logic [63:0]         byp_data_r;
  logic [63:0]         ram_q;
  logic [63:0]         s1_acc;

  // Stage 2: accumulate and write back
  logic                s2_valid_r;
  logic [ROW_W-1:0]    s2_row_r;
  item_flags_t         s2_flags_r;
  logic [32:0]         sum_re_r, sum_im_r;
  logic [63:0]         s2_acc_r;
  logic [31:0]         new_re, new_im;
  logic [63:0]         s2_new;
  logic                s2_write;
  logic [ROW_W+7:0]    row_ext;

  logic                out_valid_r;
  out_word_t           out_data_r;

  // Only a result-producing word blocked by the output register holds the pipe.
  assign adv      = !(s2_valid_r && s2_flags_r.last_col && out_valid_r && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign s2_write = adv && s2_valid_r;

  cqmva_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (accept),
    .row      (cur_row),
    .flags    (cur_flags)
  );

  cqmva_ram #(
    .DEPTH(MAX_ROWS),
    .WIDTH(64)
  ) u_acc_ram (
    .clk    (clk),
    .wr_en  (s2_write),
    .wr_addr(s2_row_r),
    .wr_data(s2_new),
    .rd_en  (accept),
    .rd_addr(cur_row),
    .rd_data(ram_q)
  );

  assign neg_vi = -in_data.vec_imag;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r   <= cur_row;
      s1_flags_r <= cur_flags;
      p_rr_r     <= in_data.mat_real * in_data.vec_real;
      p_in_r     <= in_data.mat_imag * neg_vi;
      p_iv_r     <= in_data.mat_real * in_data.vec_imag;
      p_ir_r     <= in_data.mat_imag * in_data.vec_real;
      // The RAM returns old data when the same row is written on this edge.
      byp_hit_r  <= s2_write && (s2_row_r == cur_row);
      byp_data_r <= s2_new;
    end
  end

  assign s1_acc = byp_hit_r ? byp_data_r : ram_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r   <= s1_row_r;
      s2_flags_r <= s1_flags_r;
      sum_re_r   <= {p_rr_r[31], p_rr_r} + {p_in_r[31], p_in_r};
      sum_im_r   <= {p_iv_r[31], p_iv_r} + {p_ir_r[31], p_ir_r};
      // The word ahead may be writing this row right now.
      s2_acc_r   <= (s2_valid_r && s2_row_r == s1_row_r) ? s2_new : s1_acc;
    end
  end

  always_comb begin
    if (s2_flags_r.first_col) begin
      new_re = sum_re_r[31:0];
      new_im = sum_im_r[31:0];
    end else begin
      new_re = sat_add(s2_acc_r[63:32], sum_re_r);
      new_im = sat_add(s2_acc_r[31:0], sum_im_r);
    end
  end

  assign s2_new  = {new_re, new_im};
  assign row_ext = (ROW_W + 8)'(s2_row_r);

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_flags_r.last_col) begin
      out_data_r.row_index <= row_ext[7:0];
      out_data_r.res_real  <= scale_out(new_re);
      out_data_r.res_imag  <= scale_out(new_im);
      out_data_r.last      <= s2_flags_r.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= in_valid;
        s2_valid_r <= s1_valid_r;
      end
      if (adv && s2_valid_r && s2_flags_r.last_col) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/complex_q8_matvec_accumulator_unit_checker.sv =====
// Checker for the complex Q8.8 matrix-vector accumulator: predicts each row result and compares.
module complex_q8_matvec_accumulator_unit_checker
  import cqmva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_LIMIT    = 256;
  localparam int COL_LIMIT    = 4096;
  localparam int FRAC         = 8;
  localparam int REPORT_LIMIT = 10;
  localparam longint ACC_MAX  = 64'sd2147483647;
  localparam longint ACC_MIN  = -64'sd2147483648;

  logic signed [31:0]     acc_re [ROW_LIMIT];
  logic signed [31:0]     acc_im [ROW_LIMIT];
  int unsigned            row_pos;
  int unsigned            col_pos;
  logic [ROW_COUNT_W-1:0] rows_reg;
  logic [COL_COUNT_W-1:0] cols_reg;
  out_word_t              expected_rows [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROW_LIMIT) return ROW_LIMIT;
    return rows_reg;
  endfunction

  function automatic int unsigned active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > COL_LIMIT) return COL_LIMIT;
    return cols_reg;
  endfunction

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] acc, longint term);
    longint sum;
    sum = longint'(acc) + term;
    if (sum > ACC_MAX) return 32'sh7fff_ffff;
    if (sum < ACC_MIN) return 32'sh8000_0000;
    return sum[31:0];
  endfunction

  // Arithmetic shift drops the fraction bits, then the value is clamped to int16.
  function automatic logic signed [15:0] to_q8_result(logic signed [31:0] acc);
    logic signed [31:0] shifted;
    shifted = acc >>> FRAC;
    if (shifted > 32'sd32767) return 16'sh7fff;
    if (shifted < -32'sd32768) return 16'sh8000;
    return shifted[15:0];
  endfunction

  function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                               logic [CFG_DATA_W-1:0] value);
    if (idx == REG_ROW_COUNT) begin
      rows_reg = value[ROW_COUNT_W-1:0];
    end else if (idx == REG_COLUMN_COUNT) begin
      cols_reg = value[COL_COUNT_W-1:0];
    end else begin
      return;
    end
    // Any known register write restarts the frame; accumulators are kept.
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic void accumulate_element(in_word_t w);
    int unsigned        nrows;
    int unsigned        ncols;
    int unsigned        row;
    logic signed [15:0] neg_vi;
    longint             re_term;
    longint             im_term;
    out_word_t          res;
    nrows   = active_rows();
    ncols   = active_cols();
    row     = row_pos;
    neg_vi  = -w.vec_imag;
    re_term = longint'(w.mat_real) * longint'(w.vec_real)
            + longint'(w.mat_imag) * longint'(neg_vi);
    im_term = longint'(w.mat_real) * longint'(w.vec_imag)
            + longint'(w.mat_imag) * longint'(w.vec_real);
    if (row >= nrows) row = 0;
    if (col_pos >= ncols) col_pos = 0;
    if (col_pos == 0) begin
      acc_re[row] = re_term[31:0];
      acc_im[row] = im_term[31:0];
    end else begin
      acc_re[row] = sat_add32(acc_re[row], re_term);
      acc_im[row] = sat_add32(acc_im[row], im_term);
    end
    if (col_pos + 1 == ncols) begin
      res.row_index = row[7:0];
      res.res_real  = to_q8_result(acc_re[row]);
      res.res_imag  = to_q8_result(acc_im[row]);
      res.last      = (row + 1 == nrows);
      expected_rows = {expected_rows, res};
    end
    if (row + 1 >= nrows) begin
      row_pos = 0;
      col_pos = (col_pos + 1 >= ncols) ? 0 : col_pos + 1;
    end else begin
      row_pos = row + 1;
    end
  endfunction

  function automatic void check_row_result(out_word_t got);
    out_word_t want;
    if (expected_rows.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%0t: row result with none expected: row %0d re %0d im %0d last %0b",
                 $realtime, got.row_index, got.res_real, got.res_imag, got.last);
      end
      return;
    end
    want = expected_rows.pop_front();
    if (got.row_index !== want.row_index || got.res_real !== want.res_real ||
        got.res_imag !== want.res_imag || got.last !== want.last) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%0t: row result mismatch: expected row %0d re %0d im %0d last %0b",
                 $realtime, want.row_index, want.res_real, want.res_imag, want.last);
        $display("%0t:                         got row %0d re %0d im %0d last %0b",
                 $realtime, got.row_index, got.res_real, got.res_imag, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg = ROW_COUNT_RESET;
      cols_reg = COL_COUNT_RESET;
      row_pos  = 0;
      col_pos  = 0;
      expected_rows.delete();
    end else begin
      if (cfg_we) apply_register_write(cfg_index, cfg_data);
      if (out_valid && !out_stall) check_row_result(out_data);
      if (in_valid && !in_stall) accumulate_element(in_data);
    end
    pending = expected_rows.size();
  end

endmodule

// ===== tb/complex_q8_matvec_accumulator_unit_tb.sv =====
// Testbench top for the complex Q8.8 matrix-vector accumulator: stimulus, idling and verdict.
module complex_q8_matvec_accumulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cqmva_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int OUT_HOLD_CYCLES = 150;
  localparam int PIPE_SETTLE     = 8;
  localparam int RANDOM_ITEMS    = 940;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;

  bit          in_idle_on;
  bit          out_idle_on;
  bit          out_hold_req;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  complex_q8_matvec_accumulator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  complex_q8_matvec_accumulator_unit_checker row_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold when requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (OUT_HOLD_CYCLES - 1) @(negedge clk);
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [15:0] extreme_value(int unsigned k);
    case (k)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0100;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [15:0] mr, logic [15:0] mi,
                                         logic [15:0] vr, logic [15:0] vi);
    in_word_t w;
    w.mat_real = mr;
    w.mat_imag = mi;
    w.vec_real = vr;
    w.vec_imag = vi;
    return w;
  endfunction

  function automatic logic [15:0] random_sample();
    if ($urandom_range(0, 7) == 0) return extreme_value($urandom_range(0, 5));
    return 16'($urandom);
  endfunction

  function automatic in_word_t random_word();
    return make_word(random_sample(), random_sample(), random_sample(), random_sample());
  endfunction

  // Entered and left at a falling edge; valid stays high after the word is taken.
  task automatic send_word(input in_word_t w);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    items_sent++;
  endtask

  // Lets every expected word come out and the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned rows_val, input int unsigned cols_val,
                           input int unsigned count);
    logic [CFG_DATA_W-1:0] row_value;
    row_value = CFG_DATA_W'($urandom);
    row_value[ROW_COUNT_W-1:0] = rows_val[ROW_COUNT_W-1:0];
    settle();
    if ($urandom_range(0, 3) == 0) begin
      write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    end
    if ($urandom_range(0, 1)) begin
      write_register(REG_ROW_COUNT, row_value);
      write_register(REG_COLUMN_COUNT, cols_val[CFG_DATA_W-1:0]);
    end else begin
      write_register(REG_COLUMN_COUNT, cols_val[CFG_DATA_W-1:0]);
      write_register(REG_ROW_COUNT, row_value);
    end
    repeat (count) send_word(random_word());
  endtask

  initial begin
    int unsigned rows;
    int unsigned cols;
    int unsigned extra;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ROW_COUNT;
    cfg_data     = '0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    out_hold_req = 1'b0;
    items_sent   = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Partial frame at the reset sizes; an unknown index must not restart it.
    repeat (3) send_word(random_word());
    settle();
    write_register(REG_SPARE_A, CFG_DATA_W'($urandom));
    repeat (4) send_word(random_word());
    settle();

    // One column, reset row count: every word is a result, first-column wrap included.
    write_register(REG_COLUMN_COUNT, 13'd1);
    send_word(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    repeat (15) begin
      send_word(make_word(extreme_value($urandom_range(0, 5)), extreme_value($urandom_range(0, 5)),
                          extreme_value($urandom_range(0, 5)), extreme_value($urandom_range(0, 5))));
    end
    settle();

    // Zero counts act as one.
    write_register(REG_ROW_COUNT, 13'd0);
    write_register(REG_COLUMN_COUNT, 13'd0);
    repeat (2) send_word(random_word());
    settle();

    // Two rows, two columns: drive both accumulators into saturation.
    write_register(REG_ROW_COUNT, 13'd2);
    write_register(REG_COLUMN_COUNT, 13'd2);
    send_word(make_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h8001));
    send_word(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_word(make_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h8001));
    send_word(make_word(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff));

    // Oversized row count clamps to the row limit.
    run_phase(511, 1, 256);
    run_phase(3, 5, 67);

    // Hold the result side off long enough for the block to stall its input.
    run_phase(5, 1, 0);
    in_idle_on   = 1'b0;
    out_hold_req = 1'b1;
    repeat (60) send_word(random_word());
    in_idle_on = 1'b1;
    settle();

    while (items_sent < RANDOM_ITEMS) begin
      rows  = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      cols  = $urandom_range(1, 6);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, rows * cols) : 0;
      run_phase(rows, cols, rows * cols * $urandom_range(1, 3) + extra);
    end

    // Oversized column count clamps to the column limit; a short partial frame stays silent.
    run_phase(1, 8191, 24);

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_phase(4, 3, 24);
    run_phase(1, 1, 20);
    settle();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cqmva_pkg.sv
src/cqmva_ram.sv
src/cqmva_ctrl.sv
src/complex_q8_matvec_accumulator_unit.sv
tb/complex_q8_matvec_accumulator_unit_checker.sv
tb/complex_q8_matvec_accumulator_unit_tb.sv
